>>> hw/rtl/cbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_pkg
// Shared widths, constants and the command and status bundles that pass
// between the controller and the datapath of the beatpath winner unit.
// ----------------------------------------------------------------------------
package cbw_pkg;

    localparam int CFG_W    = 5;
    localparam int CAND_W   = 4;
    localparam int RATING_W = 16;
    localparam int WIN_W    = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic tal_inc;     // tally the pair at (j, k) from the two ratings
        logic tal_clr;     // write zero at the clear address
        logic path_fw;     // path ports at (j, l) and (k, l) instead of (j, k) and (k, j)
        logic elect_init;  // forget results of the previous election
        logic row_clr;     // start a new row of the scan
        logic plain_step;  // check one pair for a loss and seed the path matrix
        logic plain_end;   // close a row of the plain winner scan
        logic via_load;    // latch the strength of the path from k to j
        logic fw_step;     // relax the path from k to l through j
        logic win_step;    // fold one path into the row's loss flag and size
        logic win_end;     // close a row of the beatpath winner scan
        logic out_load;    // load the result register
    } cmd_t;

    typedef struct packed {
        logic plain_found;
        logic out_busy;
    } stat_t;

endpackage

>>> hw/rtl/cbw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_ram
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module cbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> hw/rtl/cbw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_datapath
// Rating, tally and path memories, the pairwise compare and relax logic,
// the winner bookkeeping and the result register.
// ----------------------------------------------------------------------------
module cbw_datapath #(
    parameter int MAX_CANDIDATES = 16,
    parameter int TALLY_BITS     = 20
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  cbw_pkg::cmd_t                                    cmd,
    input  logic [$clog2(MAX_CANDIDATES+1)-1:0]              j_idx,
    input  logic [$clog2(MAX_CANDIDATES+1)-1:0]              k_idx,
    input  logic [$clog2(MAX_CANDIDATES+1)-1:0]              l_idx,
    input  logic [$clog2(MAX_CANDIDATES*MAX_CANDIDATES)-1:0] clr_addr,
    input  logic                                             in_accept,
    input  logic [cbw_pkg::CAND_W-1:0]                       candidate,
    input  logic signed [cbw_pkg::RATING_W-1:0]              rating,
    output cbw_pkg::stat_t                                   stat,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic [cbw_pkg::WIN_W-1:0]                        winner,
    output logic                                             plain_condorcet,
    output logic                                             fallback_used
);

    localparam int IW    = $clog2(MAX_CANDIDATES);
    localparam int CELLS = MAX_CANDIDATES * MAX_CANDIDATES;
    localparam int AW    = $clog2(CELLS);
    localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

    logic [IW-1:0] j_i;
    logic [IW-1:0] k_i;
    logic [IW-1:0] l_i;
    logic [AW-1:0] addr_jk;
    logic [AW-1:0] addr_kj;
    logic [AW-1:0] addr_jl;
    logic [AW-1:0] addr_kl;

    assign j_i = j_idx[IW-1:0];
    assign k_i = k_idx[IW-1:0];
    assign l_i = l_idx[IW-1:0];
    assign addr_jk = AW'(j_i) * AW'(MAX_CANDIDATES) + AW'(k_i);
    assign addr_kj = AW'(k_i) * AW'(MAX_CANDIDATES) + AW'(j_i);
    assign addr_jl = AW'(j_i) * AW'(MAX_CANDIDATES) + AW'(l_i);
    assign addr_kl = AW'(k_i) * AW'(MAX_CANDIDATES) + AW'(l_i);

    // Ratings of the current ballot.
    logic                        rat_we;
    logic [cbw_pkg::RATING_W-1:0] rat_j;
    logic [cbw_pkg::RATING_W-1:0] rat_k;

    assign rat_we = in_accept && (int'(candidate) < MAX_CANDIDATES);

    cbw_ram #(
        .WIDTH (cbw_pkg::RATING_W),
        .DEPTH (MAX_CANDIDATES)
    ) u_rating_ram (
        .clk     (clk),
        .we      (rat_we),
        .waddr   (IW'(candidate)),
        .wdata   (rating),
        .raddr_a (j_i),
        .raddr_b (k_i),
        .rdata_a (rat_j),
        .rdata_b (rat_k)
    );

    // Pairwise tally: port A reads (j, k), port B reads (k, j).
    logic                  tal_we;
    logic [AW-1:0]         tal_waddr;
    logic [TALLY_BITS-1:0] tal_wdata;
    logic [TALLY_BITS-1:0] tal_a;
    logic [TALLY_BITS-1:0] tal_b;
    logic                  k_wins;
    logic                  j_wins;

    assign k_wins = $signed(rat_k) > $signed(rat_j);
    assign j_wins = $signed(rat_j) > $signed(rat_k);

    always_comb
    begin
        tal_we    = 1'b0;
        tal_waddr = clr_addr;
        tal_wdata = '0;
        if (cmd.tal_clr)
        begin
            tal_we = 1'b1;
        end
        else if (cmd.tal_inc && k_wins)
        begin
            tal_we    = 1'b1;
            tal_waddr = addr_kj;
            tal_wdata = (tal_b == TALLY_MAX) ? tal_b : tal_b + 1'b1;
        end
        else if (cmd.tal_inc && j_wins)
        begin
            tal_we    = 1'b1;
            tal_waddr = addr_jk;
            tal_wdata = (tal_a == TALLY_MAX) ? tal_a : tal_a + 1'b1;
        end
    end

    cbw_ram #(
        .WIDTH (TALLY_BITS),
        .DEPTH (CELLS)
    ) u_tally_ram (
        .clk     (clk),
        .we      (tal_we),
        .waddr   (tal_waddr),
        .wdata   (tal_wdata),
        .raddr_a (addr_jk),
        .raddr_b (addr_kj),
        .rdata_a (tal_a),
        .rdata_b (tal_b)
    );

    // Path strengths.
    logic                  path_we;
    logic [AW-1:0]         path_waddr;
    logic [TALLY_BITS-1:0] path_wdata;
    logic [TALLY_BITS-1:0] path_a;
    logic [TALLY_BITS-1:0] path_b;
    logic [TALLY_BITS-1:0] via_reg;
    logic [TALLY_BITS-1:0] relax;
    logic [TALLY_BITS-1:0] win_s;

    assign relax = (path_a < via_reg) ? path_a : via_reg;
    assign win_s = (path_b > path_a) ? '0 : path_a;

    always_comb
    begin
        path_we    = 1'b0;
        path_waddr = addr_kj;
        path_wdata = (tal_b > tal_a) ? tal_b : '0;
        if (cmd.plain_step)
        begin
            path_we = 1'b1;
        end
        else if (cmd.fw_step)
        begin
            path_we    = relax > path_b;
            path_waddr = addr_kl;
            path_wdata = relax;
        end
    end

    cbw_ram #(
        .WIDTH (TALLY_BITS),
        .DEPTH (CELLS)
    ) u_path_ram (
        .clk     (clk),
        .we      (path_we),
        .waddr   (path_waddr),
        .wdata   (path_wdata),
        .raddr_a (cmd.path_fw ? addr_jl : addr_jk),
        .raddr_b (cmd.path_fw ? addr_kl : addr_kj),
        .rdata_a (path_a),
        .rdata_b (path_b)
    );

    // Winner bookkeeping.
    logic                        plain_found_reg;
    logic [cbw_pkg::WIN_W-1:0]   plain_idx_reg;
    logic                        best_found_reg;
    logic [cbw_pkg::WIN_W-1:0]   best_idx_reg;
    logic [TALLY_BITS-1:0]       best_size_reg;
    logic                        row_loss_reg;
    logic [TALLY_BITS-1:0]       size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            row_loss_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.elect_init)
            begin
                plain_found_reg <= 1'b0;
                best_found_reg  <= 1'b0;
            end
            if (cmd.row_clr)
            begin
                row_loss_reg <= 1'b0;
            end
            if (cmd.plain_step && (tal_b > tal_a))
            begin
                row_loss_reg <= 1'b1;
            end
            if (cmd.win_step && (win_s == '0))
            begin
                row_loss_reg <= 1'b1;
            end
            if (cmd.plain_end && !row_loss_reg && !plain_found_reg)
            begin
                plain_found_reg <= 1'b1;
            end
            if (cmd.win_end && !row_loss_reg && (!best_found_reg || size_reg > best_size_reg))
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_clr)
        begin
            size_reg <= '0;
        end
        else if (cmd.win_step && win_s > size_reg)
        begin
            size_reg <= win_s;
        end
        if (cmd.via_load)
        begin
            via_reg <= path_b;
        end
        if (cmd.plain_end && !row_loss_reg && !plain_found_reg)
        begin
            plain_idx_reg <= cbw_pkg::WIN_W'(j_idx);
        end
        if (cmd.win_end && !row_loss_reg && (!best_found_reg || size_reg > best_size_reg))
        begin
            best_idx_reg  <= cbw_pkg::WIN_W'(j_idx);
            best_size_reg <= size_reg;
        end
    end

    // Result register.
    logic                      out_valid_reg;
    logic [cbw_pkg::WIN_W-1:0] winner_reg;
    logic                      plain_reg;
    logic                      fallback_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (plain_found_reg)
            begin
                winner_reg   <= plain_idx_reg;
                plain_reg    <= 1'b1;
                fallback_reg <= 1'b0;
            end
            else
            begin
                winner_reg   <= best_found_reg ? best_idx_reg : '0;
                plain_reg    <= 1'b0;
                fallback_reg <= !best_found_reg;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign winner           = winner_reg;
    assign plain_condorcet  = plain_reg;
    assign fallback_used    = fallback_reg;
    assign stat.plain_found = plain_found_reg;
    assign stat.out_busy    = out_valid_reg && !out_ready;

endmodule

>>> hw/rtl/cbw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_ctrl
// Sequencer for the ballot tally, the plain winner scan, the widest path
// closure, the beatpath winner scan and the tally clearing pass.
// ----------------------------------------------------------------------------
module cbw_ctrl #(
    parameter int MAX_CANDIDATES = 16
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [cbw_pkg::CFG_W-1:0]                        cfg_data,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic                                             last_of_ballot,
    input  logic                                             last_of_election,
    input  cbw_pkg::stat_t                                   stat,
    output cbw_pkg::cmd_t                                    cmd,
    output logic [$clog2(MAX_CANDIDATES+1)-1:0]              j_idx,
    output logic [$clog2(MAX_CANDIDATES+1)-1:0]              k_idx,
    output logic [$clog2(MAX_CANDIDATES+1)-1:0]              l_idx,
    output logic [$clog2(MAX_CANDIDATES*MAX_CANDIDATES)-1:0] clr_addr
);

    localparam int CW    = $clog2(MAX_CANDIDATES + 1);
    localparam int CELLS = MAX_CANDIDATES * MAX_CANDIDATES;
    localparam int AW    = $clog2(CELLS);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_T_RD   = 5'd2;
    localparam logic [4:0] S_T_EX   = 5'd3;
    localparam logic [4:0] S_P_ROW  = 5'd4;
    localparam logic [4:0] S_P_RD   = 5'd5;
    localparam logic [4:0] S_P_EX   = 5'd6;
    localparam logic [4:0] S_P_END  = 5'd7;
    localparam logic [4:0] S_P_CHK  = 5'd8;
    localparam logic [4:0] S_F_K    = 5'd9;
    localparam logic [4:0] S_F_VIA  = 5'd10;
    localparam logic [4:0] S_F_RD   = 5'd11;
    localparam logic [4:0] S_F_EX   = 5'd12;
    localparam logic [4:0] S_W_ROW  = 5'd13;
    localparam logic [4:0] S_W_RD   = 5'd14;
    localparam logic [4:0] S_W_EX   = 5'd15;
    localparam logic [4:0] S_W_END  = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    logic [4:0]              state_reg, state_next;
    logic [cbw_pkg::CFG_W-1:0] cfg_reg;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           n_cfg;
    logic                    elect_reg, elect_next;
    logic [CW-1:0]           j_reg, j_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [CW-1:0]           l_reg, l_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic                    in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (int'(cfg_reg) < 2)
        begin
            n_cfg = CW'(2);
        end
        else if (int'(cfg_reg) > MAX_CANDIDATES)
        begin
            n_cfg = CW'(MAX_CANDIDATES);
        end
        else
        begin
            n_cfg = CW'(cfg_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        elect_next = elect_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        l_next     = l_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.tal_clr = 1'b1;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept && (last_of_ballot || last_of_election))
                begin
                    n_next     = n_cfg;
                    elect_next = last_of_election;
                    j_next     = '0;
                    k_next     = CW'(1);
                    state_next = S_T_RD;
                end
            end
            S_T_RD:
            begin
                state_next = S_T_EX;
            end
            S_T_EX:
            begin
                cmd.tal_inc = 1'b1;
                state_next  = S_T_RD;
                if (k_reg == n_reg - 1'b1)
                begin
                    if (j_reg == n_reg - CW'(2))
                    begin
                        j_next = '0;
                        if (elect_reg)
                        begin
                            cmd.elect_init = 1'b1;
                            state_next     = S_P_ROW;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        k_next = j_reg + CW'(2);
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_P_ROW:
            begin
                cmd.row_clr = 1'b1;
                k_next      = '0;
                state_next  = S_P_RD;
            end
            S_P_RD:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = S_P_END;
                end
                else if (k_reg == j_reg)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_P_EX;
                end
            end
            S_P_EX:
            begin
                cmd.plain_step = 1'b1;
                k_next         = k_reg + 1'b1;
                state_next     = S_P_RD;
            end
            S_P_END:
            begin
                cmd.plain_end = 1'b1;
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = S_P_CHK;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_P_ROW;
                end
            end
            S_P_CHK:
            begin
                j_next = '0;
                k_next = '0;
                if (stat.plain_found)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_F_K;
                end
            end
            S_F_K:
            begin
                if (k_reg == n_reg)
                begin
                    k_next = '0;
                    if (j_reg == n_reg - 1'b1)
                    begin
                        j_next     = '0;
                        state_next = S_W_ROW;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else if (k_reg == j_reg)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_F_VIA;
                end
            end
            S_F_VIA:
            begin
                cmd.via_load = 1'b1;
                l_next       = '0;
                state_next   = S_F_RD;
            end
            S_F_RD:
            begin
                cmd.path_fw = 1'b1;
                if (l_reg == n_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_F_K;
                end
                else if (l_reg == j_reg || l_reg == k_reg)
                begin
                    l_next = l_reg + 1'b1;
                end
                else
                begin
                    state_next = S_F_EX;
                end
            end
            S_F_EX:
            begin
                cmd.path_fw = 1'b1;
                cmd.fw_step = 1'b1;
                l_next      = l_reg + 1'b1;
                state_next  = S_F_RD;
            end
            S_W_ROW:
            begin
                cmd.row_clr = 1'b1;
                k_next      = '0;
                state_next  = S_W_RD;
            end
            S_W_RD:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = S_W_END;
                end
                else if (k_reg == j_reg)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_W_EX;
                end
            end
            S_W_EX:
            begin
                cmd.win_step = 1'b1;
                k_next       = k_reg + 1'b1;
                state_next   = S_W_RD;
            end
            S_W_END:
            begin
                cmd.win_end = 1'b1;
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_W_ROW;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    clr_next     = '0;
                    state_next   = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cfg_reg   <= cbw_pkg::CFG_RESET;
            n_reg     <= CW'(2);
            elect_reg <= 1'b0;
            j_reg     <= '0;
            k_reg     <= '0;
            l_reg     <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            elect_reg <= elect_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            l_reg     <= l_next;
            clr_reg   <= clr_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    assign j_idx    = j_reg;
    assign k_idx    = k_reg;
    assign l_idx    = l_reg;
    assign clr_addr = clr_reg;

endmodule

>>> hw/rtl/condorcet_beatpath_winner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// condorcet_beatpath_winner_unit
// Streams ballot ratings into a pairwise tally and elects a Condorcet or
// beatpath winner at the end of an election.
// ----------------------------------------------------------------------------
// A rating that does not end a ballot is taken without leaving the idle state.
// A ballot end walks the n(n-1)/2 candidate pairs through the tally memory.
// An election end runs the plain winner scan and, if that finds none, the
// widest path closure and the beatpath winner scan; the result register is
// loaded once the previous result is taken. After reset and after every
// result, the MAX_CANDIDATES^2 tally cells are cleared and no rating is taken.
module condorcet_beatpath_winner_unit #(
    parameter int MAX_CANDIDATES = 16,
    parameter int TALLY_BITS     = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbw_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cbw_pkg::CAND_W-1:0]         candidate,
    input  logic signed [cbw_pkg::RATING_W-1:0] rating,
    input  logic                               last_of_ballot,
    input  logic                               last_of_election,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cbw_pkg::WIN_W-1:0]          winner,
    output logic                               plain_condorcet,
    output logic                               fallback_used
);

    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam int AW = $clog2(MAX_CANDIDATES * MAX_CANDIDATES);

    cbw_pkg::cmd_t  cmd;
    cbw_pkg::stat_t stat;
    logic [CW-1:0]  j_idx;
    logic [CW-1:0]  k_idx;
    logic [CW-1:0]  l_idx;
    logic [AW-1:0]  clr_addr;

    cbw_ctrl #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .last_of_ballot   (last_of_ballot),
        .last_of_election (last_of_election),
        .stat             (stat),
        .cmd              (cmd),
        .j_idx            (j_idx),
        .k_idx            (k_idx),
        .l_idx            (l_idx),
        .clr_addr         (clr_addr)
    );

    cbw_datapath #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .TALLY_BITS     (TALLY_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .j_idx           (j_idx),
        .k_idx           (k_idx),
        .l_idx           (l_idx),
        .clr_addr        (clr_addr),
        .in_accept       (in_valid && in_ready),
        .candidate       (candidate),
        .rating          (rating),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .winner          (winner),
        .plain_condorcet (plain_condorcet),
        .fallback_used   (fallback_used)
    );

endmodule
